// ===== src/assert_macros.svh =====
// Assertion helpers; properties sample on clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rsvm_pkg.sv =====
package rsvm_pkg;

  localparam int NUM_REGS    = 12;
  localparam int STACK_DEPTH = 128;
  localparam int PROG_DEPTH  = 256;

  localparam int DATA_W   = 32;
  localparam int RIDX_W   = 4;
  localparam int RIDXX_W  = RIDX_W + 1;
  localparam int TGT_W    = 8;
  localparam int OUT_PC_W = 8;
  localparam int RA_W     = $clog2(NUM_REGS);
  localparam int SP_W     = $clog2(STACK_DEPTH);
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int PC_W     = $clog2(PROG_DEPTH);
  localparam int PCX_W    = PC_W + 1;
  localparam int WRAP_W   = ((PC_W > TGT_W) ? PC_W : TGT_W) + 4;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_SADD  = 4'd1,
    OP_POP   = 4'd2,
    OP_HALT  = 4'd3,
    OP_SDUMP = 4'd4,
    OP_JUMP  = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_RDUMP = 4'd8,
    OP_LDI   = 4'd9,
    OP_MUL   = 4'd10,
    OP_GETI  = 4'd11,
    OP_PRINT = 4'd12,
    OP_BEQ   = 4'd13,
    OP_BNE   = 4'd14
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_POP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_HALTED    = 2'd3
  } err_e;

  typedef struct packed {
    op_e               op;
    logic [RIDX_W-1:0] ra;
    logic [RIDX_W-1:0] rb;
    logic [RIDX_W-1:0] rc;
    logic [DATA_W-1:0] imm;
    logic [TGT_W-1:0]  tgt;
    logic [DATA_W-1:0] entered;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic [CNT_W-1:0]  cnt;
    logic              halt;
    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr;
    logic [DATA_W-1:0] rf_wdata;
    logic              st_we;
    logic [SP_W-1:0]   st_waddr;
    logic [DATA_W-1:0] st_wdata;
    kind_e             kind;
    logic [DATA_W-1:0] value;
    err_e              err;
  } exec_t;

  function automatic logic [PC_W-1:0] pc_advance(input logic [PC_W-1:0] pc,
                                                 input logic [2:0] len);
    logic [PCX_W-1:0] s;
    s = {1'b0, pc} + PCX_W'(len);
    if (s >= PCX_W'(PROG_DEPTH)) s = s - PCX_W'(PROG_DEPTH);
    return s[PC_W-1:0];
  endfunction

  function automatic logic [PC_W-1:0] wrap_target(input logic [TGT_W-1:0] t);
    logic [WRAP_W-1:0] r;
    r = WRAP_W'(t);
    for (int i = 3; i >= 0; i--) begin
      if (r >= (WRAP_W'(PROG_DEPTH) << i)) r = r - (WRAP_W'(PROG_DEPTH) << i);
    end
    return r[PC_W-1:0];
  endfunction

endpackage

// ===== src/rsvm_if.sv =====
interface rsvm_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        mode;
  logic [3:0]        reg_a;
  logic [3:0]        reg_b;
  logic [3:0]        reg_c;
  logic signed [31:0] immediate;
  logic [7:0]        jump_target;
  logic signed [31:0] entered_value;

  modport source (output valid, mode, reg_a, reg_b, reg_c, immediate, jump_target,
                  entered_value, input ready);
  modport sink (input valid, mode, reg_a, reg_b, reg_c, immediate, jump_target,
                entered_value, output ready);
endinterface

interface rsvm_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        next_pc;
  logic [1:0]        value_kind;
  logic signed [31:0] value;
  logic              halted;
  logic [1:0]        error;

  modport source (output valid, next_pc, value_kind, value, halted, error, input ready);
  modport sink (input valid, next_pc, value_kind, value, halted, error, output ready);
endinterface

// ===== src/rsvm_ram.sv =====
module rsvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write-first on both read ports
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (we_i && waddr_i == raddr_a_i) rdata_a_q <= wdata_i;
    else rdata_a_q <= mem_q[raddr_a_i];
    if (we_i && waddr_i == raddr_b_i) rdata_b_q <= wdata_i;
    else rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/rsvm_regfile.sv =====
module rsvm_regfile import rsvm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [RIDX_W-1:0] raddr_a_i,
  input  logic [RIDX_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o,
  input  logic              we_i,
  input  logic [RIDX_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i
);

  logic [NUM_REGS-1:0] valid_q;
  logic                ok_a_q;
  logic                ok_b_q;
  logic                ok_a_d;
  logic                ok_b_d;
  logic                wr_ok;
  logic                rd_in_a;
  logic                rd_in_b;
  logic [DATA_W-1:0]   ram_a;
  logic [DATA_W-1:0]   ram_b;

  assign wr_ok   = we_i && ({1'b0, waddr_i} < RIDXX_W'(NUM_REGS));
  assign rd_in_a = {1'b0, raddr_a_i} < RIDXX_W'(NUM_REGS);
  assign rd_in_b = {1'b0, raddr_b_i} < RIDXX_W'(NUM_REGS);

  // unwritten or out-of-range registers read as zero
  assign ok_a_d = rd_in_a && (valid_q[raddr_a_i[RA_W-1:0]] ||
                              (wr_ok && waddr_i == raddr_a_i));
  assign ok_b_d = rd_in_b && (valid_q[raddr_b_i[RA_W-1:0]] ||
                              (wr_ok && waddr_i == raddr_b_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ok_a_q  <= 1'b0;
      ok_b_q  <= 1'b0;
    end else begin
      if (wr_ok) valid_q[waddr_i[RA_W-1:0]] <= 1'b1;
      ok_a_q <= ok_a_d;
      ok_b_q <= ok_b_d;
    end
  end

  rsvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_ok),
    .waddr_i   (waddr_i[RA_W-1:0]),
    .wdata_i   (wdata_i),
    .raddr_a_i (raddr_a_i[RA_W-1:0]),
    .raddr_b_i (raddr_b_i[RA_W-1:0]),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  assign rdata_a_o = ok_a_q ? ram_a : '0;
  assign rdata_b_o = ok_b_q ? ram_b : '0;

endmodule

// ===== src/rsvm_exec.sv =====
module rsvm_exec import rsvm_pkg::*; (
  input  instr_t            instr_i,
  input  logic [DATA_W-1:0] rf_a_i,
  input  logic [DATA_W-1:0] rf_b_i,
  input  logic [DATA_W-1:0] st_top_i,
  input  logic [DATA_W-1:0] st_next_i,
  input  logic [PC_W-1:0]   pc_i,
  input  logic [CNT_W-1:0]  cnt_i,
  input  logic              halt_i,
  output exec_t             exec_o
);

  logic [DATA_W-1:0] prod;

  assign prod = rf_a_i * rf_b_i;

  always_comb begin
    exec_o          = '0;
    exec_o.pc       = pc_advance(pc_i, 3'd1);
    exec_o.cnt      = cnt_i;
    exec_o.halt     = halt_i;
    exec_o.rf_waddr = instr_i.ra;
    exec_o.st_waddr = cnt_i[SP_W-1:0];
    exec_o.kind     = KIND_NONE;
    exec_o.err      = ERR_NONE;
    if (halt_i) begin
      exec_o.pc  = pc_i;
      exec_o.err = ERR_HALTED;
    end else begin
      case (instr_i.op)
        OP_PUSH: begin
          exec_o.pc = pc_advance(pc_i, 3'd2);
          if (cnt_i >= CNT_W'(STACK_DEPTH)) begin
            exec_o.err = ERR_OVERFLOW;
          end else begin
            exec_o.st_we    = 1'b1;
            exec_o.st_wdata = instr_i.imm;
            exec_o.cnt      = cnt_i + CNT_W'(1);
          end
        end
        OP_SADD: begin
          if (cnt_i < CNT_W'(2)) begin
            exec_o.err = ERR_UNDERFLOW;
          end else begin
            exec_o.st_we    = 1'b1;
            exec_o.st_waddr = SP_W'(cnt_i - CNT_W'(2));
            exec_o.st_wdata = st_top_i + st_next_i;
            exec_o.cnt      = cnt_i - CNT_W'(1);
          end
        end
        OP_POP: begin
          if (cnt_i == '0) begin
            exec_o.err = ERR_UNDERFLOW;
          end else begin
            exec_o.cnt   = cnt_i - CNT_W'(1);
            exec_o.kind  = KIND_POP;
            exec_o.value = st_top_i;
          end
        end
        OP_HALT: begin
          exec_o.halt = 1'b1;
        end
        OP_JUMP: begin
          exec_o.pc = wrap_target(instr_i.tgt);
        end
        OP_ADD: begin
          exec_o.pc       = pc_advance(pc_i, 3'd4);
          exec_o.rf_we    = 1'b1;
          exec_o.rf_wdata = rf_a_i + rf_b_i;
        end
        OP_SUB: begin
          exec_o.pc       = pc_advance(pc_i, 3'd4);
          exec_o.rf_we    = 1'b1;
          exec_o.rf_wdata = rf_a_i - rf_b_i;
        end
        OP_MUL: begin
          exec_o.pc       = pc_advance(pc_i, 3'd4);
          exec_o.rf_we    = 1'b1;
          exec_o.rf_wdata = prod;
        end
        OP_LDI: begin
          exec_o.pc       = pc_advance(pc_i, 3'd3);
          exec_o.rf_we    = 1'b1;
          exec_o.rf_wdata = instr_i.imm;
        end
        OP_GETI: begin
          exec_o.pc       = pc_advance(pc_i, 3'd2);
          exec_o.rf_we    = 1'b1;
          exec_o.rf_wdata = instr_i.entered;
        end
        OP_PRINT: begin
          exec_o.pc    = pc_advance(pc_i, 3'd2);
          exec_o.kind  = KIND_PRINT;
          exec_o.value = rf_a_i;
        end
        OP_BEQ: begin
          exec_o.pc = (rf_a_i == rf_b_i) ? wrap_target(instr_i.tgt)
                                         : pc_advance(pc_i, 3'd4);
        end
        OP_BNE: begin
          exec_o.pc = (rf_a_i != rf_b_i) ? wrap_target(instr_i.tgt)
                                         : pc_advance(pc_i, 3'd4);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/register_stack_vm_execute.sv =====
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   mode reg_a reg_b reg_c immediate jump_target entered_value
// out_o    out  valid/ready   next_pc value_kind value halted error
//
// One instruction per cycle sustained while results are not stalled; the result passes
// through the input register, then execute into the result register.
// Register file and operand stack are write-first RAMs whose reads are issued
// in the cycle before execute, so a dependency never stalls the pipeline.
// Reset clears pc, stack count, halt and register valid bits; no clearing pass.
// A stalled result holds execute, then the input register; otherwise a new
// transaction is taken in every cycle.
`include "assert_macros.svh"

module register_stack_vm_execute import rsvm_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  rsvm_in_if.sink     in_i,
  rsvm_out_if.source  out_o
);

  logic              in_acc;
  logic              exec_go;
  logic              s1_valid_q;
  instr_t            instr_q;
  instr_t            instr_in;
  instr_t            rd_instr;
  logic              arith;
  logic [RIDX_W-1:0] rf_raddr_a;
  logic [RIDX_W-1:0] rf_raddr_b;
  logic [DATA_W-1:0] rf_a;
  logic [DATA_W-1:0] rf_b;
  logic [DATA_W-1:0] st_top;
  logic [DATA_W-1:0] st_next;
  logic [PC_W-1:0]   pc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_d;
  logic              halt_q;
  exec_t             x;

  logic              out_valid_q;
  logic [PC_W-1:0]   out_pc_q;
  kind_e             out_kind_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_halt_q;
  err_e              out_err_q;

  assign exec_go    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || exec_go;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    instr_in.op      = op_e'(in_i.mode);
    instr_in.ra      = in_i.reg_a;
    instr_in.rb      = in_i.reg_b;
    instr_in.rc      = in_i.reg_c;
    instr_in.imm     = in_i.immediate;
    instr_in.tgt     = in_i.jump_target;
    instr_in.entered = in_i.entered_value;
  end

  // issue register reads for whatever sits in execute next cycle
  assign rd_instr   = in_acc ? instr_in : instr_q;
  assign arith      = rd_instr.op == OP_ADD || rd_instr.op == OP_SUB ||
                      rd_instr.op == OP_MUL;
  assign rf_raddr_a = arith ? rd_instr.rb : rd_instr.ra;
  assign rf_raddr_b = arith ? rd_instr.rc : rd_instr.rb;

  assign cnt_d = exec_go ? x.cnt : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      cnt_q       <= '0;
      halt_q      <= 1'b0;
    end else begin
      s1_valid_q  <= in_acc || (s1_valid_q && !exec_go);
      out_valid_q <= exec_go || (out_valid_q && !out_o.ready);
      cnt_q       <= cnt_d;
      if (exec_go) begin
        pc_q   <= x.pc;
        halt_q <= x.halt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) instr_q <= instr_in;
    if (exec_go) begin
      out_pc_q    <= x.pc;
      out_kind_q  <= x.kind;
      out_value_q <= x.value;
      out_halt_q  <= x.halt;
      out_err_q   <= x.err;
    end
  end

  rsvm_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .raddr_a_i (rf_raddr_a),
    .raddr_b_i (rf_raddr_b),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b),
    .we_i      (exec_go && x.rf_we),
    .waddr_i   (x.rf_waddr),
    .wdata_i   (x.rf_wdata)
  );

  rsvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (exec_go && x.st_we),
    .waddr_i   (x.st_waddr),
    .wdata_i   (x.st_wdata),
    .raddr_a_i (SP_W'(cnt_d - CNT_W'(1))),
    .raddr_b_i (SP_W'(cnt_d - CNT_W'(2))),
    .rdata_a_o (st_top),
    .rdata_b_o (st_next)
  );

  rsvm_exec u_exec (
    .instr_i   (instr_q),
    .rf_a_i    (rf_a),
    .rf_b_i    (rf_b),
    .st_top_i  (st_top),
    .st_next_i (st_next),
    .pc_i      (pc_q),
    .cnt_i     (cnt_q),
    .halt_i    (halt_q),
    .exec_o    (x)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.next_pc    = OUT_PC_W'(out_pc_q);
  assign out_o.value_kind = out_kind_q;
  assign out_o.value      = out_value_q;
  assign out_o.halted     = out_halt_q;
  assign out_o.error      = out_err_q;

  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt flag cleared")
  `ASSERT_NEXT(a_halt_freeze, halt_q, $stable(pc_q) && $stable(cnt_q), "state moved after halt")
  `ASSERT_IMPL(a_halted_err, out_valid_q && out_err_q == ERR_HALTED, halt_q && out_halt_q, "halted error without halt")

endmodule
